>>> rtl/core/fmwq_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the FIFO-queued mutex.
package fmwq_pkg;

    localparam int TASK_W = 6;

    typedef enum logic [1:0] {
        FUNC_ACQUIRE = 2'd0,
        FUNC_TRY     = 2'd1,
        FUNC_RELEASE = 2'd2,
        FUNC_FORCE   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ERR_NONE   = 3'd0,
        ERR_TWICE  = 3'd1,
        ERR_UNHELD = 3'd2,
        ERR_OWNER  = 3'd3,
        ERR_FULL   = 3'd4
    } err_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        func_t              func;
        logic [TASK_W-1:0]  task_id;
    } req_t;

    typedef struct packed {
        logic               granted;
        logic               blocked;
        logic               woken_valid;
        logic [TASK_W-1:0]  woken_task;
        err_t               error;
    } rsp_t;

    // State updates chosen by the decision logic for one transaction.
    typedef struct packed {
        logic grant;
        logic enqueue;
        logic handover;
        logic free;
    } action_t;

endpackage

>>> rtl/core/fmwq_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, registered-read RAM.
module fmwq_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/fmwq_decide.sv
`timescale 1ns / 1ps
// Decision logic: picks the state update and the result for one request.
module fmwq_decide
    import fmwq_pkg::*;
#(
    parameter int MAX_TASKS = 64
)
(
    input  req_t                           req,
    input  logic                           locked,
    input  logic [TASK_W-1:0]              owner,
    input  logic [$clog2(MAX_TASKS+1)-1:0] count,
    input  logic [TASK_W-1:0]              head_task,
    output action_t                        act,
    output rsp_t                           rsp
);

    localparam int CW = $clog2(MAX_TASKS + 1);

    always_comb
    begin
        act = '0;
        rsp = '0;
        rsp.error = ERR_NONE;
        unique case (req.func) inside
            FUNC_ACQUIRE:
            begin
                if (!locked)
                begin
                    act.grant   = 1'b1;
                    rsp.granted = 1'b1;
                end
                else if (owner == req.task_id)
                begin
                    rsp.error = ERR_TWICE;
                end
                else if (count == CW'(MAX_TASKS))
                begin
                    rsp.error = ERR_FULL;
                end
                else
                begin
                    act.enqueue = 1'b1;
                    rsp.blocked = 1'b1;
                end
            end
            FUNC_TRY:
            begin
                if (!locked)
                begin
                    act.grant   = 1'b1;
                    rsp.granted = 1'b1;
                end
            end
            FUNC_RELEASE, FUNC_FORCE:
            begin
                if (!locked)
                begin
                    rsp.error = ERR_UNHELD;
                end
                else if (req.func == FUNC_RELEASE && owner != req.task_id)
                begin
                    rsp.error = ERR_OWNER;
                end
                else if (count != '0)
                begin
                    act.handover    = 1'b1;
                    rsp.woken_valid = 1'b1;
                    rsp.woken_task  = head_task;
                end
                else
                begin
                    act.free = 1'b1;
                end
            end
            default:
            begin
                act = '0;
            end
        endcase
    end

endmodule

>>> rtl/core/fifo_mutex_with_wait_queue.sv
`timescale 1ns / 1ps
// Top level of the FIFO-queued mutex with owner tracking.
//
// A request (operation and task) is a transaction accepted at a rising edge
// where start is high and busy is low. Every request yields exactly one
// result: done is high for one cycle with the result on rsp, and the
// receiver takes it at the edge that ends that cycle; it cannot stall.
//
// The waiter queue lives in a RAM with a registered read. At acceptance the
// RAM is read at the queue head, so the oldest waiter is on hand in the
// following execute cycle, where the lock, owner, head and count registers
// are updated and an enqueue writes the tail entry. The result is
// registered and shown in the cycle after execute.
//
// The request is registered at the accepting edge, the block is busy in its
// execute state, and done and the result are registered at the edge that
// ends execute. No new request is accepted while busy; a new request may be
// accepted at the edge that ends the cycle in which done is shown.
//
// Reset frees the lock, clears the owner and empties the queue; the queue
// RAM itself is not cleared, as only entries that were written are used.
module fifo_mutex_with_wait_queue
    import fmwq_pkg::*;
#(
    parameter int MAX_TASKS = 64
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output rsp_t rsp
);

    localparam int HW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);

    state_t            state_reg, state_next;
    req_t              req_reg;
    logic              locked_reg;
    logic [TASK_W-1:0] owner_reg;
    logic [HW-1:0]     head_reg;
    logic [CW-1:0]     count_reg;
    logic              done_reg;
    rsp_t              rsp_reg;

    logic              accept;
    logic              exec;
    logic [TASK_W-1:0] head_task;
    logic [CW:0]       tail_sum;
    logic [HW-1:0]     tail;
    logic [HW-1:0]     head_inc;
    action_t           act;
    rsp_t              rsp_calc;

    assign busy   = (state_reg == ST_EXEC);
    assign accept = start && !busy;
    assign exec   = (state_reg == ST_EXEC);

    // Tail slot of the circular queue, wrapped for any depth.
    assign tail_sum = (CW+1)'(head_reg) + (CW+1)'(count_reg);
    assign tail     = (tail_sum >= (CW+1)'(MAX_TASKS))
                      ? HW'(tail_sum - (CW+1)'(MAX_TASKS))
                      : HW'(tail_sum);
    assign head_inc = (head_reg == HW'(MAX_TASKS - 1)) ? '0 : head_reg + 1'b1;

    fmwq_ram #(
        .WIDTH (TASK_W),
        .DEPTH (MAX_TASKS)
    ) u_queue (
        .clk   (clk),
        .we    (exec && act.enqueue),
        .waddr (tail),
        .wdata (req_reg.task_id),
        .re    (accept),
        .raddr (head_reg),
        .rdata (head_task)
    );

    fmwq_decide #(
        .MAX_TASKS (MAX_TASKS)
    ) u_decide (
        .req       (req_reg),
        .locked    (locked_reg),
        .owner     (owner_reg),
        .count     (count_reg),
        .head_task (head_task),
        .act       (act),
        .rsp       (rsp_calc)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            locked_reg <= 1'b0;
            owner_reg  <= '0;
            head_reg   <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= exec;
            if (exec)
            begin
                if (act.grant)
                begin
                    locked_reg <= 1'b1;
                    owner_reg  <= req_reg.task_id;
                end
                if (act.enqueue)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                if (act.handover)
                begin
                    owner_reg <= head_task;
                    head_reg  <= head_inc;
                    count_reg <= count_reg - 1'b1;
                end
                if (act.free)
                begin
                    locked_reg <= 1'b0;
                    owner_reg  <= '0;
                end
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (exec)
        begin
            rsp_reg <= rsp_calc;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

>>> rtl/core/fmwq_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the FIFO-queued mutex, bound to the top level.
module fmwq_checker
    import fmwq_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input req_t req,
    input logic done,
    input rsp_t rsp
);

    // An accepted transaction makes the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted transaction");

    // Each accepted transaction is answered with done once its execute state ends.
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##2 done)
        else $error("result missing two cycles after acceptance");

    // No result appears without a matching accepted transaction.
    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without a matching transaction");

    // An error leaves every other result field clear.
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.error != ERR_NONE |->
            !rsp.granted && !rsp.blocked && !rsp.woken_valid && rsp.woken_task == '0)
        else $error("error result carries other fields");

    // At most one outcome, and a woken task only when one was woken.
    a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $onehot0({rsp.granted, rsp.blocked, rsp.woken_valid})
            && (rsp.woken_valid || rsp.woken_task == '0))
        else $error("result reports conflicting outcomes");

endmodule

bind fifo_mutex_with_wait_queue fmwq_checker u_fmwq_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
);
